// ===== rtl/ptrt_pkg.sv =====
package ptrt_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned FUNC_W    = 3;
	localparam int unsigned ID_W      = 4;
	// late limit is four periods: a shift by two
	localparam int unsigned LATE_SHIFT = 2;

	localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_CONSUME = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_MARK    = 3'd4;

	// one table entry: last release above period
	typedef struct packed {
		logic [TIME_W-1:0] last_release;
		logic [TIME_W-1:0] period;
	} ptrt_entry_t;

	typedef struct packed {
		logic        mem_we;
		ptrt_entry_t mem_wdata;
		logic        set_present;
		logic        time_we;
		logic        known;
		logic        run;
	} ptrt_res_t;

endpackage

// ===== rtl/periodic_task_release_table_core.sv =====
// Channel   Dir  Content (tdata / tuser from bit 0 up)
// s_axis    in   tdata: task_id[3:0], period_us[35:4], time_us[67:36], zero pad
//                tuser: func[2:0]
// m_axis    out  tdata: task_known[0], run[1], zero pad
//
// Flow: an item is accepted and its table entry read at that edge; the result moves
// into the output register once that register is free. One item is in flight at a
// time, set by the table read-modify-write: no new item is taken until it moves on.
// Reset: clears the present bits, the current time and all handshake state; the
// table RAM is not cleared, since an entry counts only once its present bit is set.
// Stalls: a waiting result holds the item in flight, which holds s_axis_tready low.
module periodic_task_release_table_core
	import ptrt_pkg::*;
#(
	parameter int unsigned NUM_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // task_id, period_us, time_us, pad
	input  logic [2:0]  s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // task_known, run, pad
);

	localparam int unsigned AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	// input field split
	logic [ID_W-1:0]   in_id;
	logic [TIME_W-1:0] in_period;
	logic [TIME_W-1:0] in_time;
	logic              in_accept;

	assign in_id     = s_axis_tdata[3:0];
	assign in_period = s_axis_tdata[35:4];
	assign in_time   = s_axis_tdata[67:36];

	// stage 1: item waiting on its table read
	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [AW-1:0]     addr_s1;
	logic              id_ok_s1;
	logic [TIME_W-1:0] period_s1;
	logic [TIME_W-1:0] time_s1;

	logic [NUM_TASKS-1:0] present_q;
	logic [TIME_W-1:0]    cur_time_q;
	logic                 out_valid_q;
	logic                 out_known_q;
	logic                 out_run_q;

	logic        advance;
	logic        present_s1;
	ptrt_entry_t rd_entry;
	ptrt_res_t   res;

	// hold a new item back while one is in flight: read and write back never overlap
	assign s_axis_tready = !valid_s1;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	// drain stage 1 once the output register is free or being emptied
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);

	assign present_s1 = id_ok_s1 && present_q[addr_s1];

	ptrt_ram #(
		.WIDTH($bits(ptrt_entry_t)),
		.DEPTH(NUM_TASKS)
	) u_table (
		.clk  (clk),
		.we   (advance && res.mem_we),
		.waddr(addr_s1),
		.wdata(res.mem_wdata),
		.re   (in_accept),
		.raddr(in_id[AW-1:0]),
		.rdata(rd_entry)
	);

	ptrt_exec u_exec (
		.func     (func_s1),
		.id_ok    (id_ok_s1),
		.present  (present_s1),
		.period_in(period_s1),
		.cur_time (cur_time_q),
		.entry    (rd_entry),
		.res      (res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			present_q   <= '0;
			cur_time_q  <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && res.set_present) begin
				present_q[addr_s1] <= 1'b1;
			end
			if (advance && res.time_we) begin
				cur_time_q <= time_s1;
			end
		end
	end

	// payload: capture the item, then the result
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1   <= s_axis_tuser;
			addr_s1   <= in_id[AW-1:0];
			id_ok_s1  <= ({1'b0, in_id} < 5'(NUM_TASKS));
			period_s1 <= in_period;
			time_s1   <= in_time;
		end
		if (advance) begin
			out_known_q <= res.known;
			out_run_q   <= res.run;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_run_q, out_known_q};

	// interlock: an accepted item holds off the next one
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready)
		else $error("item accepted while another in flight");

	// present bits only ever get set
	a_present_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((present_q & $past(present_q)) == $past(present_q)))
		else $error("present bit cleared");

	// a due task must be a known one
	a_run_known: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_run_q) |-> out_known_q)
		else $error("run reported for unknown task");

	// table writes come only from a completing item
	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(res.mem_we && advance) |-> (valid_s1 && !in_accept))
		else $error("table write without item in flight");

endmodule

// ===== rtl/ptrt_ram.sv =====
module ptrt_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ptrt_exec.sv =====
module ptrt_exec
	import ptrt_pkg::*;
(
	input  logic [FUNC_W-1:0] func,
	input  logic              id_ok,
	input  logic              present,
	input  logic [TIME_W-1:0] period_in,
	input  logic [TIME_W-1:0] cur_time,
	input  ptrt_entry_t       entry,
	output ptrt_res_t         res
);

	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] late;
	logic              known;
	logic              due;

	assign known   = id_ok && present;
	assign elapsed = cur_time - entry.last_release;
	assign late    = entry.period << LATE_SHIFT;
	assign due     = (elapsed >= entry.period);

	always_comb begin
		res             = '0;
		res.mem_wdata   = entry;
		res.known       = known;
		case (func)
			FUNC_ADD: begin
				res.known = id_ok;
				if (id_ok && !present) begin
					res.mem_we                 = 1'b1;
					res.mem_wdata.period       = period_in;
					res.mem_wdata.last_release = '0;
					res.set_present            = 1'b1;
				end
			end
			FUNC_UPDATE: begin
				res.time_we = 1'b1;
			end
			FUNC_CONSUME: begin
				if (known && due) begin
					res.run    = 1'b1;
					res.mem_we = 1'b1;
					if (elapsed > late) begin
						res.mem_wdata.last_release = cur_time;
					end else begin
						res.mem_wdata.last_release = entry.last_release + entry.period;
					end
				end
			end
			FUNC_QUERY: begin
				res.run = known && due;
			end
			FUNC_MARK: begin
				if (known) begin
					res.mem_we                 = 1'b1;
					res.mem_wdata.last_release = cur_time;
				end
			end
			default: begin
				res.known = known;
			end
		endcase
	end

endmodule

// ===== test/tb_periodic_task_release_table_core.sv =====
`timescale 1ns / 1ps

module tb_periodic_task_release_table_core;
	import ptrt_pkg::*;

	localparam int unsigned NUM_TASKS    = 8;
	localparam int unsigned RANDOM_ITEMS = 1030;
	// a consume more than this many periods late jumps to the current time
	localparam logic [31:0] LATE_FACTOR  = 32'd4;
	// func codes with no operation behind them
	localparam logic [FUNC_W-1:0] FUNC_RSVD_A = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_B = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_C = 3'd7;

	typedef struct packed {
		logic known;
		logic run;
	} status_t;

	// Shadow of the release table plus the queue of statuses still owed by the block.
	class ptrt_scoreboard;
		logic [31:0] now_us;
		logic [31:0] period_us [NUM_TASKS];
		logic [31:0] release_us [NUM_TASKS];
		bit          present [NUM_TASKS];
		status_t     expected_status [$];
		int          errors;

		function new();
			now_us = '0;
			errors = 0;
			foreach (present[i]) begin
				period_us[i] = '0;
				release_us[i] = '0;
				present[i] = 1'b0;
			end
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function void report(string msg);
			$display("[%0t] status error: %s", $time, msg);
			errors++;
		endfunction

		// Apply one accepted item to the shadow table and queue the status it owes.
		function void predict_status(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
				logic [31:0] per, logic [31:0] tim);
			int          idx;
			bit          valid;
			bit          found;
			bit          run;
			logic [31:0] elapsed;
			status_t     st;
			idx = id;
			valid = (idx < NUM_TASKS);
			found = 1'b0;
			run = 1'b0;
			elapsed = '0;
			if (valid) begin
				found = present[idx];
			end
			if (found) begin
				elapsed = now_us - release_us[idx];
			end
			case (func)
				FUNC_ADD: begin
					// a second add of the same task keeps its period and release
					if (valid && !present[idx]) begin
						period_us[idx] = per;
						release_us[idx] = '0;
						present[idx] = 1'b1;
						found = 1'b1;
					end
				end
				FUNC_UPDATE: begin
					now_us = tim;
				end
				FUNC_CONSUME: begin
					if (found && elapsed >= period_us[idx]) begin
						run = 1'b1;
						if (elapsed > period_us[idx] * LATE_FACTOR) begin
							release_us[idx] = now_us;
						end else begin
							release_us[idx] = release_us[idx] + period_us[idx];
						end
					end
				end
				FUNC_QUERY: begin
					if (found) begin
						run = (elapsed >= period_us[idx]);
					end
				end
				FUNC_MARK: begin
					if (found) begin
						release_us[idx] = now_us;
					end
				end
				default: begin
				end
			endcase
			st.known = found;
			st.run = run;
			expected_status.push_back(st);
		endfunction

		function void check_status(logic [7:0] data);
			status_t st;
			if (expected_status.size() == 0) begin
				report($sformatf("item with nothing owed: known=%0b run=%0b",
					data[0], data[1]));
				return;
			end
			st = expected_status.pop_front();
			if (data[0] !== st.known) begin
				report($sformatf("task_known %0b, predicted %0b", data[0], st.known));
			end
			if (data[1] !== st.run) begin
				report($sformatf("run %0b, predicted %0b", data[1], st.run));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;   // task_id[3:0], period_us[35:4], time_us[67:36], pad
	logic [2:0]  s_axis_tuser = '0;   // func[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // task_known[0], run[1], pad

	ptrt_scoreboard sb = new();

	// calm: both sides stop idling; hold_left: receiver back-pressure still to apply
	bit calm = 1'b0;
	int hold_left = 0;

	always #1 clk = ~clk;

	periodic_task_release_table_core #(
		.NUM_TASKS(NUM_TASKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Offer one item, with random idle cycles up front, and hold it until accepted.
	task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
			input logic [31:0] per, input logic [31:0] tim);
		while (!calm && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {4'd0, tim, per, id};
		do @(posedge clk); while (!s_axis_tready);
		sb.predict_status(func, id, per, tim);
	endtask

	// Drop valid and hold off until every owed status has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) begin
			@(posedge clk);
		end
	endtask

	// Receiver: check accepted statuses, then pick the next tready.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_status(m_axis_tdata);
			end
			if (hold_left > 0) begin
				// long back-pressure: the block fills and must stall its input
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
			end
		end
	end

	// Stimulus
	initial begin
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   id;
		logic [31:0]       per;
		logic [31:0]       tim;
		logic [31:0]       stim_now;
		int unsigned       pick;
		int unsigned       r;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unknown tasks: absent, out of range, and the spare func codes.
		send_item(FUNC_QUERY, 4'd0, 32'd0, 32'd0);
		send_item(FUNC_CONSUME, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(FUNC_MARK, 4'd8, 32'd0, 32'd0);
		send_item(FUNC_RSVD_A, 4'd0, 32'd0, 32'd0);
		// Zero period is due at once; a repeated add must leave the task alone.
		send_item(FUNC_ADD, 4'd0, 32'd0, 32'd0);
		send_item(FUNC_ADD, 4'd0, 32'd100, 32'd0);
		send_item(FUNC_QUERY, 4'd0, 32'd0, 32'd0);
		send_item(FUNC_RSVD_B, 4'd0, 32'd0, 32'd0);
		send_item(FUNC_RSVD_C, 4'd7, 32'd0, 32'd0);
		// Widest period, an ordinary one, and an add of an out-of-range id.
		send_item(FUNC_ADD, 4'd7, 32'hFFFF_FFFF, 32'd0);
		send_item(FUNC_ADD, 4'd1, 32'd100, 32'd0);
		send_item(FUNC_ADD, 4'd8, 32'd5, 32'd0);
		// Time at the top: both tasks due and far behind, so consume jumps them.
		send_item(FUNC_UPDATE, 4'd3, 32'd0, 32'hFFFF_FFFF);
		send_item(FUNC_QUERY, 4'd7, 32'd0, 32'd0);
		send_item(FUNC_CONSUME, 4'd7, 32'd0, 32'd0);
		send_item(FUNC_CONSUME, 4'd1, 32'd0, 32'd0);
		// Time wraps past zero: elapsed still counts across the wrap.
		send_item(FUNC_UPDATE, 4'd1, 32'd0, 32'd50);
		send_item(FUNC_QUERY, 4'd1, 32'd0, 32'd0);
		// Exactly one period elapsed: consume advances by one period, wrapping.
		send_item(FUNC_UPDATE, 4'd0, 32'd0, 32'd99);
		send_item(FUNC_CONSUME, 4'd1, 32'd0, 32'd0);
		send_item(FUNC_MARK, 4'd1, 32'd0, 32'd0);
		send_item(FUNC_QUERY, 4'd1, 32'd0, 32'd0);
		// Four periods wrap to zero, so any due consume counts as late.
		send_item(FUNC_ADD, 4'd2, 32'h4000_0000, 32'd0);
		send_item(FUNC_UPDATE, 4'd2, 32'd0, 32'h4000_0001);
		send_item(FUNC_CONSUME, 4'd2, 32'd0, 32'd0);

		stim_now = 32'h4000_0001;
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 250 && n < 450);
			if (n == 500) begin
				hold_left = 300;
			end
			if (n == 750) begin
				drain();
			end
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 12) begin
				id = 4'($urandom_range(NUM_TASKS, 15));
			end else begin
				id = 4'($urandom_range(0, NUM_TASKS - 1));
			end
			per = $urandom;
			tim = $urandom;
			if (pick < 8) begin
				func = FUNC_ADD;
				r = $urandom_range(0, 19);
				if (r == 0) begin
					per = 32'd0;
				end else if (r == 1) begin
					per = 32'h3FFF_FFFE + $urandom_range(0, 4);
				end else if (r > 3) begin
					per = $urandom_range(1, 200);
				end
			end else if (pick < 33) begin
				func = FUNC_UPDATE;
				r = $urandom_range(0, 19);
				if (r < 17) begin
					stim_now = stim_now + $urandom_range(0, 400);
				end else if (r < 19) begin
					stim_now = $urandom;
				end else begin
					stim_now = stim_now - $urandom_range(1, 255);
				end
				tim = stim_now;
			end else if (pick < 63) begin
				func = FUNC_CONSUME;
			end else if (pick < 83) begin
				func = FUNC_QUERY;
			end else if (pick < 93) begin
				func = FUNC_MARK;
			end else begin
				func = 3'($urandom_range(FUNC_RSVD_A, FUNC_RSVD_C));
			end
			send_item(func, id, per, tim);
		end
		calm = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ptrt_pkg.sv
rtl/ptrt_ram.sv
rtl/ptrt_exec.sv
rtl/periodic_task_release_table_core.sv
test/tb_periodic_task_release_table_core.sv
